FILE: rtl/assert_macros.svh
// Assertion macros for the RTL file that carries checks, the comparator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

FILE: rtl/pcc_pkg.sv
// Package for the path collation comparator: character codes, class ranks, helpers.
package pcc_pkg;

    typedef logic [7:0] t_char;
    typedef logic [4:0] t_rank;

    // Verdict on one character pair
    typedef struct packed {
        logic differ;      // pair differs after case folding
        logic fault;       // pair cannot be ordered
        logic left_first;  // left byte sorts first
    } t_pair_verdict;

    // Character codes
    localparam t_char CH_SPACE   = 8'h20;
    localparam t_char CH_BANG    = 8'h21;
    localparam t_char CH_HASH    = 8'h23;
    localparam t_char CH_DOLLAR  = 8'h24;
    localparam t_char CH_PERCENT = 8'h25;
    localparam t_char CH_AMP     = 8'h26;
    localparam t_char CH_QUOTE   = 8'h27;
    localparam t_char CH_LPAREN  = 8'h28;
    localparam t_char CH_RPAREN  = 8'h29;
    localparam t_char CH_PLUS    = 8'h2B;
    localparam t_char CH_COMMA   = 8'h2C;
    localparam t_char CH_MINUS   = 8'h2D;
    localparam t_char CH_DOT     = 8'h2E;
    localparam t_char CH_SLASH   = 8'h2F;
    localparam t_char CH_ZERO    = 8'h30;
    localparam t_char CH_NINE    = 8'h39;
    localparam t_char CH_SEMI    = 8'h3B;
    localparam t_char CH_EQUAL   = 8'h3D;
    localparam t_char CH_AT      = 8'h40;
    localparam t_char CH_UPPER_A = 8'h41;
    localparam t_char CH_UPPER_Z = 8'h5A;
    localparam t_char CH_LBRACK  = 8'h5B;
    localparam t_char CH_BSLASH  = 8'h5C;
    localparam t_char CH_RBRACK  = 8'h5D;
    localparam t_char CH_CARET   = 8'h5E;
    localparam t_char CH_UNDER   = 8'h5F;
    localparam t_char CH_GRAVE   = 8'h60;
    localparam t_char CH_LOWER_A = 8'h61;
    localparam t_char CH_LOWER_Z = 8'h7A;
    localparam t_char CH_LBRACE  = 8'h7B;
    localparam t_char CH_RBRACE  = 8'h7D;
    localparam t_char CH_TILDE   = 8'h7E;
    localparam t_char CH_HIGH    = 8'h80;
    localparam t_char CASE_DELTA = 8'h20;

    // Class ranks, lowest sorts first
    localparam t_rank RANK_SLASH   = 5'd0;
    localparam t_rank RANK_SPACE   = 5'd1;
    localparam t_rank RANK_BANG    = 5'd2;
    localparam t_rank RANK_HASH    = 5'd3;
    localparam t_rank RANK_DOLLAR  = 5'd4;
    localparam t_rank RANK_PERCENT = 5'd5;
    localparam t_rank RANK_AMP     = 5'd6;
    localparam t_rank RANK_QUOTE   = 5'd7;
    localparam t_rank RANK_LPAREN  = 5'd8;
    localparam t_rank RANK_RPAREN  = 5'd9;
    localparam t_rank RANK_PLUS    = 5'd10;
    localparam t_rank RANK_COMMA   = 5'd11;
    localparam t_rank RANK_MINUS   = 5'd12;
    localparam t_rank RANK_DOT     = 5'd13;
    localparam t_rank RANK_DIGIT   = 5'd14;
    localparam t_rank RANK_SEMI    = 5'd15;
    localparam t_rank RANK_EQUAL   = 5'd16;
    localparam t_rank RANK_AT      = 5'd17;
    localparam t_rank RANK_LETTER  = 5'd18;
    localparam t_rank RANK_LBRACK  = 5'd19;
    localparam t_rank RANK_RBRACK  = 5'd20;
    localparam t_rank RANK_CARET   = 5'd21;
    localparam t_rank RANK_UNDER   = 5'd22;
    localparam t_rank RANK_GRAVE   = 5'd23;
    localparam t_rank RANK_LBRACE  = 5'd24;
    localparam t_rank RANK_RBRACE  = 5'd25;
    localparam t_rank RANK_TILDE   = 5'd26;
    localparam t_rank RANK_HIGH    = 5'd27;
    localparam t_rank RANK_UNDEC   = 5'd28;

    // Fold upper-case letters to lower case
    function automatic t_char f_fold(input t_char c);
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            return c + CASE_DELTA;
        end
        return c;
    endfunction

    // Map a byte to its collation class rank
    function automatic t_rank f_rank(input t_char c);
        t_rank rk;
        rk = RANK_UNDEC;
        if (c >= CH_HIGH) begin
            rk = RANK_HIGH;
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            rk = RANK_DIGIT;
        end else if ((c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
                     (c >= CH_LOWER_A && c <= CH_LOWER_Z)) begin
            rk = RANK_LETTER;
        end else begin
            unique case (c)
                CH_SLASH, CH_BSLASH: rk = RANK_SLASH;
                CH_SPACE:            rk = RANK_SPACE;
                CH_BANG:             rk = RANK_BANG;
                CH_HASH:             rk = RANK_HASH;
                CH_DOLLAR:           rk = RANK_DOLLAR;
                CH_PERCENT:          rk = RANK_PERCENT;
                CH_AMP:              rk = RANK_AMP;
                CH_QUOTE:            rk = RANK_QUOTE;
                CH_LPAREN:           rk = RANK_LPAREN;
                CH_RPAREN:           rk = RANK_RPAREN;
                CH_PLUS:             rk = RANK_PLUS;
                CH_COMMA:            rk = RANK_COMMA;
                CH_MINUS:            rk = RANK_MINUS;
                CH_DOT:              rk = RANK_DOT;
                CH_SEMI:             rk = RANK_SEMI;
                CH_EQUAL:            rk = RANK_EQUAL;
                CH_AT:               rk = RANK_AT;
                CH_LBRACK:           rk = RANK_LBRACK;
                CH_RBRACK:           rk = RANK_RBRACK;
                CH_CARET:            rk = RANK_CARET;
                CH_UNDER:            rk = RANK_UNDER;
                CH_GRAVE:            rk = RANK_GRAVE;
                CH_LBRACE:           rk = RANK_LBRACE;
                CH_RBRACE:           rk = RANK_RBRACE;
                CH_TILDE:            rk = RANK_TILDE;
                default:             rk = RANK_UNDEC;
            endcase
        end
        return rk;
    endfunction

endpackage

FILE: rtl/path_collation_comparator_top.sv
// Top level of the path collation comparator: input register, decision state, result register.
//
// Usage: the sender streams one character pair per beat on the input channel
// (i_valid / o_ready) with left/right bytes, their present flags and last_pair
// on the final position of a comparison. Exactly one result beat
// (o_valid / i_ready) leaves per comparison, carrying o_left_first and
// o_fault; beats without last_pair produce no result.
// Throughput: one pair per cycle while no last_pair beat waits for room in the
// result register; one rank lookup and compare sit between the input register
// and the result register. The result of a last_pair beat passes the input
// register, then the result register.
// Stall: while the result register is full and i_ready is low, beats without
// last_pair keep flowing into the decision state; the next last_pair beat
// waits in the input register and o_ready drops. No beat is lost or repeated.
// Reset (i_rst_n low, synchronous): both registers empty, decision state
// cleared. Each comparison also clears the state on its last_pair beat.
`include "assert_macros.svh"

module path_collation_comparator_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_left_char,
    input  logic [7:0] i_right_char,
    input  logic       i_left_present,
    input  logic       i_right_present,
    input  logic       i_last_pair,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_left_first,
    output logic       o_fault
);

    // input register
    logic           r_s1_valid;
    pcc_pkg::t_char r_s1_left_char;
    pcc_pkg::t_char r_s1_right_char;
    logic           r_s1_left_present;
    logic           r_s1_right_present;
    logic           r_s1_last;

    // decision state
    logic r_decided;
    logic r_result;
    logic r_fault_seen;
    logic n_decided;
    logic n_result;
    logic n_fault_seen;

    // result register
    logic r_out_valid;
    logic r_out_left_first;
    logic r_out_fault;

    logic                   in_fire;
    logic                   s1_fire;
    logic                   out_free;
    pcc_pkg::t_pair_verdict verdict;

    pcc_pair_order u_pair_order (
        .i_left_char  (r_s1_left_char),
        .i_right_char (r_s1_right_char),
        .o_verdict    (verdict)
    );

    // Handshake: a last beat needs room in the result register
    assign out_free = !r_out_valid || i_ready;
    assign s1_fire  = r_s1_valid && (!r_s1_last || out_free);
    assign o_ready  = !r_s1_valid || s1_fire;
    assign in_fire  = i_valid && o_ready;

    // Capture the incoming beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_left_char     <= i_left_char;
            r_s1_right_char    <= i_right_char;
            r_s1_left_present  <= i_left_present;
            r_s1_right_present <= i_right_present;
            r_s1_last          <= i_last_pair;
        end
    end

    // Fold the pair into the decision; hold once decided
    always_comb begin
        n_decided    = r_decided;
        n_result     = r_result;
        n_fault_seen = r_fault_seen;
        if (!r_decided) begin
            if (r_s1_left_present && r_s1_right_present) begin
                if (verdict.differ) begin
                    n_decided    = 1'b1;
                    n_result     = verdict.left_first;
                    n_fault_seen = verdict.fault;
                end
            end else begin
                // shorter path sorts first
                n_decided = 1'b1;
                n_result  = r_s1_right_present;
            end
        end
    end

    // Advance the decision state; drop it at the end of a comparison
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decided    <= 1'b0;
            r_result     <= 1'b0;
            r_fault_seen <= 1'b0;
        end else if (s1_fire) begin
            if (r_s1_last) begin
                r_decided    <= 1'b0;
                r_result     <= 1'b0;
                r_fault_seen <= 1'b0;
            end else begin
                r_decided    <= n_decided;
                r_result     <= n_result;
                r_fault_seen <= n_fault_seen;
            end
        end
    end

    // Load the result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_last) begin
            r_out_left_first <= n_decided && n_result;
            r_out_fault      <= n_fault_seen;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_left_first = r_out_left_first;
    assign o_fault      = r_out_fault;

    // Checks
    `ASSERT_IMPL(a_fault_implies_decided, i_clk, i_rst_n, r_fault_seen, r_decided && !r_result)
    `ASSERT_IMPL(a_fault_not_first, i_clk, i_rst_n, o_valid && o_fault, !o_left_first)
    `ASSERT_NEXT(a_state_cleared, i_clk, i_rst_n, s1_fire && r_s1_last, !r_decided && !r_fault_seen)

endmodule

FILE: rtl/pcc_pair_order.sv
// Combinational ordering of one character pair by collation class.
module pcc_pair_order (
    input  pcc_pkg::t_char        i_left_char,
    input  pcc_pkg::t_char        i_right_char,
    output pcc_pkg::t_pair_verdict o_verdict
);

    pcc_pkg::t_char l_fold;
    pcc_pkg::t_char r_fold;
    pcc_pkg::t_rank l_rank;
    pcc_pkg::t_rank r_rank;
    logic           l_loose;
    logic           r_loose;

    assign l_fold = pcc_pkg::f_fold(i_left_char);
    assign r_fold = pcc_pkg::f_fold(i_right_char);
    assign l_rank = pcc_pkg::f_rank(i_left_char);
    assign r_rank = pcc_pkg::f_rank(i_right_char);

    // High/unclassed bytes order vs classed ones; two such only if both are high
    assign l_loose = (l_rank == pcc_pkg::RANK_HIGH) || (l_rank == pcc_pkg::RANK_UNDEC);
    assign r_loose = (r_rank == pcc_pkg::RANK_HIGH) || (r_rank == pcc_pkg::RANK_UNDEC);

    // Loose pairs may fault; else class, then code; left wins between separators
    always_comb begin
        o_verdict.differ     = (l_fold != r_fold);
        o_verdict.fault      = 1'b0;
        o_verdict.left_first = 1'b0;
        priority if (l_loose && r_loose &&
                     !(l_rank == pcc_pkg::RANK_HIGH && r_rank == pcc_pkg::RANK_HIGH)) begin
            o_verdict.fault = 1'b1;
        end else if (l_rank != r_rank) begin
            o_verdict.left_first = (l_rank < r_rank);
        end else if (l_rank == pcc_pkg::RANK_SLASH) begin
            // two different separators: left side wins
            o_verdict.left_first = 1'b1;
        end else begin
            o_verdict.left_first = (l_fold < r_fold);
        end
    end

endmodule
